### rtl/core/csv_field_tokenizer_defines.svh
// Assertion macros shared by the CSV tokenizer RTL.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// The expression must never hold at a clock edge outside reset.
`define CSVFT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("csvft assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CSVFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvft assertion failed");

`else

`define CSVFT_ASSERT_NEVER(label, clk, rst_n, expr)
`define CSVFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/csvft_pkg.sv
// Types, constants and helpers shared by the CSV tokenizer.
package csvft_pkg;

    // Counter widths; result fields show the low bits.
    localparam int COLUMN_BITS = 8;
    localparam int ROW_BITS    = 24;
    localparam int FIELD_IDX_W = 8;
    localparam int RECORD_IDX_W = 24;

    // Result queue between the parser and the output port.
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int MAX_PER_IN = 3;

    // Special bytes.
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] SEP_RESET  = 8'h2C;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_STRAY_QUOTE = 2'd0;
    localparam logic [1:0] ERR_JUNK        = 2'd1;
    localparam logic [1:0] ERR_OPEN_QUOTE  = 2'd2;
    localparam logic [1:0] ERR_NONE        = 2'd0;

    typedef logic [COLUMN_BITS-1:0] t_col;
    typedef logic [ROW_BITS-1:0]    t_row;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              kind;
        logic [7:0]              out_byte;
        logic [1:0]              error_code;
        logic [FIELD_IDX_W-1:0]  field_index;
        logic [RECORD_IDX_W-1:0] record_index;
        logic                    last;
    } t_result;

    // Builds one result tagged with the current counters.
    function automatic t_result make_result(logic [1:0] kind, logic [7:0] data,
                                            logic [1:0] code, t_col col, t_row row);
        t_result r;
        r.kind         = kind;
        r.out_byte     = data;
        r.error_code   = code;
        r.field_index  = FIELD_IDX_W'(col);
        r.record_index = RECORD_IDX_W'(row);
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

### rtl/core/csv_field_tokenizer.sv
// Streaming CSV tokenizer: one text byte in, up to three result beats out.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_result)
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (separator)
//
// An input beat lands in an input register; the parser turns it, once the queue has
// room, into zero to three results, which are written into an 8-entry result queue.
// The queue drains one beat per cycle while i_out_ready is high.
// The parser fires only while the queue has room for three results, so output
// stalls back up into o_in_ready without losing or repeating any beat.
// Synchronous active-low reset clears the parser state, the queue and sets the
// separator to a comma; the configuration port is always ready.
`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csvft_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csvft_pkg::t_result  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    // Configuration register.
    logic [7:0] r_sep;

    // Input register.
    logic                r_in_valid;
    csvft_pkg::t_in_item r_in;

    // Parser state.
    logic            r_iq, r_afs, r_qp, r_acq, r_crp;
    csvft_pkg::t_col r_col;
    csvft_pkg::t_row r_row;

    // Working copies of the state while the byte is parsed.
    logic            n_iq, n_afs, n_qp, n_acq, n_crp;
    csvft_pkg::t_col n_col;
    csvft_pkg::t_row n_row;
    logic [1:0]      n_cnt;
    logic            w_consumed;
    logic [7:0]      w_b;
    csvft_pkg::t_result w_res [csvft_pkg::MAX_PER_IN];

    // Result queue.
    csvft_pkg::t_result                r_q [csvft_pkg::QDEPTH];
    logic [csvft_pkg::QPTR_W-1:0]      r_head, r_tail;
    logic [csvft_pkg::QCNT_W-1:0]      r_count;
    logic                              w_space, w_proc, w_pop;

    localparam csvft_pkg::t_col COL_MAX = '1;
    localparam csvft_pkg::t_row ROW_MAX = '1;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign w_space     = r_count <= csvft_pkg::QCNT_W'(csvft_pkg::QDEPTH - csvft_pkg::MAX_PER_IN);
    assign w_proc      = r_in_valid && w_space;
    assign o_in_ready  = !r_in_valid || w_space;
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_q[r_head];
    assign w_pop       = o_out_valid && i_out_ready;
    assign w_b         = r_in.in_byte;

    // Parse one byte: walk the rules in order, appending results as they arise.
    always_comb begin
        n_iq  = r_iq;
        n_afs = r_afs;
        n_qp  = r_qp;
        n_acq = r_acq;
        n_crp = r_crp;
        n_col = r_col;
        n_row = r_row;
        n_cnt = 2'd0;
        w_consumed = 1'b0;
        for (int k = 0; k < csvft_pkg::MAX_PER_IN; k++) begin
            w_res[k] = '0;
        end

        // A held CR either pairs with LF or is released first.
        if (n_crp) begin
            if (w_b == csvft_pkg::LF_BYTE) begin
                n_crp = 1'b0;
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_RECORD, 8'd0,
                                                      csvft_pkg::ERR_NONE, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
                n_col = '0;
                if (n_row != ROW_MAX) n_row = n_row + 1'b1;
                n_afs = 1'b1;
                n_acq = 1'b0;
                n_iq  = 1'b0;
                n_qp  = 1'b0;
                w_consumed = 1'b1;
            end else begin
                n_crp = 1'b0;
                if (n_acq) begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_ERROR, 8'd0,
                                                          csvft_pkg::ERR_JUNK, n_col, n_row);
                end else begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_DATA,
                                                          csvft_pkg::CR_BYTE,
                                                          csvft_pkg::ERR_NONE, n_col, n_row);
                    n_afs = 1'b0;
                end
                n_cnt = n_cnt + 2'd1;
            end
        end

        // Quoted-field handling.
        if (!w_consumed) begin
            if (n_qp) begin
                n_qp = 1'b0;
                if (w_b == csvft_pkg::QUOTE_BYTE) begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_DATA, w_b,
                                                          csvft_pkg::ERR_NONE, n_col, n_row);
                    n_cnt = n_cnt + 2'd1;
                    n_afs = 1'b0;
                    n_iq  = 1'b1;
                    w_consumed = 1'b1;
                end else begin
                    n_acq = 1'b1;
                end
            end else if (n_iq) begin
                if (w_b == csvft_pkg::QUOTE_BYTE) begin
                    n_qp = 1'b1;
                    n_iq = 1'b0;
                end else begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_DATA, w_b,
                                                          csvft_pkg::ERR_NONE, n_col, n_row);
                    n_cnt = n_cnt + 2'd1;
                    n_afs = 1'b0;
                end
                w_consumed = 1'b1;
            end
        end

        // Delimiters, quotes at field start and plain data.
        if (!w_consumed) begin
            if (w_b == csvft_pkg::LF_BYTE) begin
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_RECORD, 8'd0,
                                                      csvft_pkg::ERR_NONE, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
                n_col = '0;
                if (n_row != ROW_MAX) n_row = n_row + 1'b1;
                n_afs = 1'b1;
                n_acq = 1'b0;
                n_iq  = 1'b0;
                n_qp  = 1'b0;
            end else if (!n_acq && w_b == csvft_pkg::QUOTE_BYTE) begin
                if (n_afs) begin
                    n_iq  = 1'b1;
                    n_afs = 1'b0;
                end else begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_ERROR, 8'd0,
                                                          csvft_pkg::ERR_STRAY_QUOTE,
                                                          n_col, n_row);
                    n_cnt = n_cnt + 2'd1;
                end
            end else if (w_b == r_sep) begin
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_FIELD, 8'd0,
                                                      csvft_pkg::ERR_NONE, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
                if (n_col != COL_MAX) n_col = n_col + 1'b1;
                n_afs = 1'b1;
                n_acq = 1'b0;
            end else if (w_b == csvft_pkg::CR_BYTE) begin
                n_crp = 1'b1;
            end else if (n_acq) begin
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_ERROR, 8'd0,
                                                      csvft_pkg::ERR_JUNK, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
            end else begin
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_DATA, w_b,
                                                      csvft_pkg::ERR_NONE, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
                n_afs = 1'b0;
            end
        end

        // End of input: flush a held CR, report open quotes, close the record.
        if (r_in.end_of_input) begin
            if (n_crp) begin
                n_crp = 1'b0;
                if (n_acq) begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_ERROR, 8'd0,
                                                          csvft_pkg::ERR_JUNK, n_col, n_row);
                end else begin
                    w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_DATA,
                                                          csvft_pkg::CR_BYTE,
                                                          csvft_pkg::ERR_NONE, n_col, n_row);
                    n_afs = 1'b0;
                end
                n_cnt = n_cnt + 2'd1;
            end
            if (n_iq) begin
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_ERROR, 8'd0,
                                                      csvft_pkg::ERR_OPEN_QUOTE, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
            end
            if (!n_afs || n_col != '0 || n_iq || n_qp) begin
                w_res[n_cnt] = csvft_pkg::make_result(csvft_pkg::KIND_RECORD, 8'd0,
                                                      csvft_pkg::ERR_NONE, n_col, n_row);
                n_cnt = n_cnt + 2'd1;
            end
            n_iq  = 1'b0;
            n_afs = 1'b1;
            n_qp  = 1'b0;
            n_acq = 1'b0;
            n_crp = 1'b0;
            n_col = '0;
            n_row = '0;
        end

        // Mark the final result of this byte.
        if (n_cnt != 2'd0) begin
            w_res[n_cnt - 2'd1].last = 1'b1;
        end
    end

    // Configuration, input register and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep      <= csvft_pkg::SEP_RESET;
            r_in_valid <= 1'b0;
            r_iq       <= 1'b0;
            r_afs      <= 1'b1;
            r_qp       <= 1'b0;
            r_acq      <= 1'b0;
            r_crp      <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sep <= i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_iq  <= n_iq;
                r_afs <= n_afs;
                r_qp  <= n_qp;
                r_acq <= n_acq;
                r_crp <= n_crp;
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Input payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (w_proc) begin
                r_tail <= r_tail + csvft_pkg::QPTR_W'(n_cnt);
            end
            r_count <= r_count
                       + (w_proc ? csvft_pkg::QCNT_W'(n_cnt) : '0)
                       - csvft_pkg::QCNT_W'(w_pop);
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            for (int k = 0; k < csvft_pkg::MAX_PER_IN; k++) begin
                if (2'(k) < n_cnt) begin
                    r_q[csvft_pkg::QPTR_W'(r_tail + csvft_pkg::QPTR_W'(k))] <= w_res[k];
                end
            end
        end
    end

    // Checks on the queue and parser state.
    `CSVFT_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > csvft_pkg::QCNT_W'(csvft_pkg::QDEPTH))
    `CSVFT_ASSERT_NEXT(a_held_item, i_clk, i_rst_n, r_in_valid && !w_proc, r_in_valid)
    `CSVFT_ASSERT_NEVER(a_quote_flags, i_clk, i_rst_n, r_qp && r_iq)
    `CSVFT_ASSERT_NEVER(a_closed_quote, i_clk, i_rst_n, r_acq && r_iq)

endmodule

### bench/tb_top.sv
// Self-checking testbench for the streaming CSV field tokenizer.
`timescale 1ns / 100ps

module tb_top;
    import csvft_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 150;
    localparam int ITEMS_PER_PHASE = 16;

    // Clock, reset and the block's ports.
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_ready;
    logic       out_valid;
    logic       cfg_ready;
    t_result    out_beat;

    // Tokenizer state as the bench predicts it.
    logic [7:0] sep_reg;
    logic       in_quotes;
    logic       field_start;
    logic       quote_seen;
    logic       after_close;
    logic       cr_held;
    t_col       col_count;
    t_row       row_count;

    // Results still owed by the block, oldest first, and the text being sent.
    t_result    expected_results[$];
    logic [7:0] text_q[$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    csv_field_tokenizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    // Parser state returns here after reset and after the final byte of a text.
    function automatic void clear_parse();
        in_quotes   = 1'b0;
        field_start = 1'b1;
        quote_seen  = 1'b0;
        after_close = 1'b0;
        cr_held     = 1'b0;
        col_count   = '0;
        row_count   = '0;
    endfunction

    // Queues one result tagged with the current field and record numbers.
    function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic [1:0] code);
        t_result r;
        r.kind         = kind;
        r.out_byte     = data;
        r.error_code   = code;
        r.field_index  = col_count;
        r.record_index = row_count;
        r.last         = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void emit_data(logic [7:0] b);
        add_result(KIND_DATA, b, ERR_NONE);
        field_start = 1'b0;
    endfunction

    // Field end: the column count sticks at its maximum.
    function automatic void close_field();
        add_result(KIND_FIELD, 8'h00, ERR_NONE);
        if (col_count != '1) begin
            col_count++;
        end
        field_start = 1'b1;
        after_close = 1'b0;
    endfunction

    // Record end: also closes the record's final field and any open quotes.
    function automatic void close_record();
        add_result(KIND_RECORD, 8'h00, ERR_NONE);
        col_count = '0;
        if (row_count != '1) begin
            row_count++;
        end
        field_start = 1'b1;
        after_close = 1'b0;
        in_quotes   = 1'b0;
        quote_seen  = 1'b0;
    endfunction

    // A held CR that is not followed by LF is data, or junk after a closing quote.
    function automatic void release_cr();
        cr_held = 1'b0;
        if (after_close) begin
            add_result(KIND_ERROR, 8'h00, ERR_JUNK);
        end else begin
            emit_data(CR_BYTE);
        end
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        // A quote inside quotes is either doubled or closes the field.
        if (quote_seen) begin
            quote_seen = 1'b0;
            if (b == QUOTE_BYTE) begin
                emit_data(b);
                in_quotes = 1'b1;
                return;
            end
            after_close = 1'b1;
        end else if (in_quotes) begin
            if (b == QUOTE_BYTE) begin
                quote_seen = 1'b1;
                in_quotes  = 1'b0;
            end else begin
                emit_data(b);
            end
            return;
        end
        if (after_close) begin
            if (b == LF_BYTE) begin
                close_record();
            end else if (b == sep_reg) begin
                close_field();
            end else if (b == CR_BYTE) begin
                cr_held = 1'b1;
            end else begin
                add_result(KIND_ERROR, 8'h00, ERR_JUNK);
            end
        end else if (b == LF_BYTE) begin
            close_record();
        end else if (b == QUOTE_BYTE) begin
            if (field_start) begin
                in_quotes   = 1'b1;
                field_start = 1'b0;
            end else begin
                add_result(KIND_ERROR, 8'h00, ERR_STRAY_QUOTE);
            end
        end else if (b == sep_reg) begin
            close_field();
        end else if (b == CR_BYTE) begin
            cr_held = 1'b1;
        end else begin
            emit_data(b);
        end
    endfunction

    // Works out every result that one accepted input beat causes.
    function automatic void tokenize(t_in_item it);
        int first;
        first = expected_results.size();
        if (cr_held && it.in_byte == LF_BYTE) begin
            cr_held = 1'b0;
            close_record();
        end else begin
            if (cr_held) begin
                release_cr();
            end
            scan_byte(it.in_byte);
        end
        // The final byte flushes a held CR, reports an open quote and closes an open record.
        if (it.end_of_input) begin
            if (cr_held) begin
                release_cr();
            end
            if (in_quotes) begin
                add_result(KIND_ERROR, 8'h00, ERR_OPEN_QUOTE);
            end
            if (!field_start || col_count != '0 || in_quotes || quote_seen) begin
                close_record();
            end
            clear_parse();
        end
        if (expected_results.size() > first) begin
            expected_results[expected_results.size() - 1].last = 1'b1;
        end
    endfunction

    // Offers one input beat after a random gap and waits until it is taken.
    task automatic send_item(logic [7:0] b, logic eoi);
        t_in_item it;
        it.in_byte      = b;
        it.end_of_input = eoi;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        tokenize(it);
    endtask

    task automatic send_text(string s, logic eoi_last);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], eoi_last && (i == s.len() - 1));
        end
    endtask

    // Stops sending and waits until every owed result has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_separator(logic [7:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) begin
            @(posedge i_clk);
        end
        sep_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // Mostly printable text, with some raw bytes and every special byte.
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            return 8'($urandom_range(8'h20, 8'h7E));
        end else if (pick < 15) begin
            return 8'($urandom_range(0, 255));
        end else if (pick == 15) begin
            return sep_reg;
        end else if (pick == 16 || pick == 19) begin
            return CR_BYTE;
        end else if (pick == 17) begin
            return LF_BYTE;
        end
        return QUOTE_BYTE;
    endfunction

    // Builds one record into text_q; returns 1 when it ends without a line break.
    function automatic bit build_record();
        int fields;
        int len;
        int style;
        int ending;
        logic [7:0] b;
        text_q.delete();
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            style = $urandom_range(0, 9);
            len   = $urandom_range(0, 5);
            if (style < 4) begin
                // Quoted field with doubled quotes; at times the closing
                // quote is missing or junk follows it.
                text_q.push_back(QUOTE_BYTE);
                for (int k = 0; k < len; k++) begin
                    b = text_byte();
                    text_q.push_back(b);
                    if (b == QUOTE_BYTE) begin
                        text_q.push_back(QUOTE_BYTE);
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    text_q.push_back(QUOTE_BYTE);
                end
                if ($urandom_range(0, 9) == 0) begin
                    text_q.push_back(text_byte());
                end
            end else if (style < 9) begin
                for (int k = 0; k < len; k++) begin
                    text_q.push_back(text_byte());
                end
            end else begin
                for (int k = 0; k <= len; k++) begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (f != fields - 1) begin
                text_q.push_back(sep_reg);
            end
        end
        ending = $urandom_range(0, 3);
        if (ending == 0) begin
            text_q.push_back(LF_BYTE);
        end else if (ending != 3) begin
            text_q.push_back(CR_BYTE);
            text_q.push_back(LF_BYTE);
        end
        return ending == 3;
    endfunction

    // Sends random records until about count bytes have gone in.
    task automatic send_random_items(int count);
        int sent;
        int n;
        bit ends_text;
        sent = 0;
        while (sent < count) begin
            ends_text = build_record() || ($urandom_range(0, 7) == 0);
            n = text_q.size();
            for (int i = 0; i < n; i++) begin
                send_item(text_q[i], (ends_text && i == n - 1) ||
                                     ($urandom_range(0, 99) == 0));
                sent++;
            end
        end
    endtask

    // Separator, stray quote, doubled quote, junk after a closing quote,
    // CR LF, and a lone CR as data, also after stray quotes.
    task automatic test_directed_fields();
        send_text("a\"b,\"c\"\"d\"x", 1'b0);
        send_item(CR_BYTE, 1'b0);
        send_item(LF_BYTE, 1'b0);
        send_item(CR_BYTE, 1'b0);
        send_text("1\"q\"", 1'b0);
        send_item(CR_BYTE, 1'b0);
        send_text("2", 1'b1);
    endtask

    // Byte extremes and the ways a text can end.
    task automatic test_directed_endings();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_text("\"o", 1'b1);
        send_item(CR_BYTE, 1'b1);
        send_item(LF_BYTE, 1'b1);
    endtask

    // More fields in one record than the field index can count.
    task automatic test_column_saturation();
        send_item("x", 1'b0);
        repeat (260) send_item(sep_reg, 1'b0);
        send_item(LF_BYTE, 1'b0);
    endtask

    // The receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_random_items(40);
        wait_idle();
    endtask

    task automatic run_phase(logic [7:0] sep, int send_pct, int recv_pct);
        set_separator(sep);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_random_items(ITEMS_PER_PHASE);
    endtask

    // Random records under several separators and idling patterns.
    task automatic test_separator_sweep();
        run_phase(8'h09, 0, 0);
        run_phase(8'h00, 72, 0);
        run_phase(8'hFF, 0, 72);
        run_phase(CR_BYTE, 24, 24);
        run_phase(QUOTE_BYTE, 72, 0);
        run_phase(LF_BYTE, 0, 72);
        run_phase(SEP_RESET, 24, 24);
    endtask

    // Receiver ready: random stalls, or a long hold when a test asks for one.
    always @(posedge i_clk) begin : drive_out_ready
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // Each result beat must match the oldest owed result.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing owed: kind %0d, byte %0h",
                       out_beat.kind, out_beat.out_byte);
                errors++;
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", want.kind, out_beat.kind);
                compare_field("out_byte", want.out_byte, out_beat.out_byte);
                compare_field("error_code", want.error_code, out_beat.error_code);
                compare_field("field_index", want.field_index, out_beat.field_index);
                compare_field("record_index", want.record_index, out_beat.record_index);
                compare_field("last", want.last, out_beat.last);
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL csv_field_tokenizer");
        $finish;
    end

    initial begin : main_sequence
        sep_reg = SEP_RESET;
        clear_parse();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_fields();
        test_directed_endings();
        test_column_saturation();
        test_backpressure();
        test_separator_sweep();
        wait_idle();
        if (errors == 0) begin
            $display("PASS csv_field_tokenizer");
        end else begin
            $display("FAIL csv_field_tokenizer");
        end
        $finish;
    end

endmodule
